### rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned CODE_FIELD_W = 30;
  localparam int unsigned LEN_FIELD_W  = 5;

  // Packer window: pending bits plus one longest code, top aligned
  localparam int unsigned WIN_W   = 40;
  localparam int unsigned TOTAL_W = 6;

  // Queue between table lookup and packer
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  // One looked-up code on its way to the packer
  typedef struct packed {
    logic                   last;
    logic [LEN_FIELD_W-1:0]  len;
    logic [CODE_FIELD_W-1:0] code;
  } hcbp_entry_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] free;
  } hcbp_qstat_t;

endpackage

### rtl/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hcbp_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hcbp_front.sv
// Front end: accepts words, loads the code table and looks up codes to encode.
module hcbp_front
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [SYM_W-1:0]        symbol_i,
  input  logic [CODE_FIELD_W-1:0] code_value_i,
  input  logic [LEN_FIELD_W-1:0]  code_length_i,
  input  logic                    last_i,
  input  hcbp_qstat_t             qstat_i,
  output logic                    push_o,
  output hcbp_entry_t             entry_o
);

  localparam int unsigned CODE_W = (MAX_CODE_BITS > CODE_FIELD_W) ? CODE_FIELD_W
                                                                  : MAX_CODE_BITS;
  localparam int unsigned LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int unsigned ROW_W  = CODE_W + LEN_W;

  logic              accept;
  logic              in_range;
  logic              tbl_we;
  logic              tbl_re;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] code_mask;
  logic [ROW_W-1:0]  tbl_wdata;
  logic [ROW_W-1:0]  tbl_rdata;
  logic              rd_pending_q;
  logic              rd_last_q;
  logic              rd_in_range_q;

  // Accept unless the queue may lack room for a lookup in flight
  assign in_stall_o = (qstat_i.free == '0) ||
                      ((qstat_i.free == QCNT_W'(1)) && rd_pending_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, symbol_i} < (SYM_W + 1)'(SYMBOL_COUNT));

  // Table row: saturated length over masked code
  always_comb begin
    len_sat   = (code_length_i > LEN_FIELD_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                              : LEN_W'(code_length_i);
    code_mask = ~({CODE_W{1'b1}} << len_sat);
    tbl_wdata = {len_sat, code_value_i[CODE_W-1:0] & code_mask};
  end

  assign tbl_we = accept && (kind_i == KIND_LOAD) && in_range;
  assign tbl_re = accept && (kind_i == KIND_ENCODE);

  hcbp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (symbol_i[ADDR_W-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (symbol_i[ADDR_W-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Lookup in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pending_q <= 1'b0;
    end else begin
      rd_pending_q <= tbl_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_re) begin
      rd_last_q     <= last_i;
      rd_in_range_q <= in_range;
    end
  end

  // Out-of-range symbols carry no bits
  always_comb begin
    push_o        = rd_pending_q;
    entry_o.last  = rd_last_q;
    entry_o.len   = rd_in_range_q ? LEN_FIELD_W'(tbl_rdata[CODE_W +: LEN_W]) : '0;
    entry_o.code  = rd_in_range_q ? CODE_FIELD_W'(tbl_rdata[CODE_W-1:0]) : '0;
  end

endmodule

### rtl/hcbp_fifo.sv
// Short queue of looked-up codes between the front end and the packer.
module hcbp_fifo
  import hcbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hcbp_entry_t entry_i,
  input  logic        pop_i,
  output hcbp_entry_t head_o,
  output hcbp_qstat_t qstat_o
);

  hcbp_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.free  = QCNT_W'(QUEUE_DEPTH) - cnt_q;

endmodule

### rtl/hcbp_back.sv
// Packer: appends codes MSB first and emits full and flushed bytes.
module hcbp_back
  import hcbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcbp_entry_t       head_i,
  input  hcbp_qstat_t       qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_state_e;

  back_state_e        state_q;
  logic [WIN_W-1:0]   window_q;
  logic [TOTAL_W-1:0] total_q;
  logic               last_q;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               out_last_q;

  logic               out_free;
  logic               emit;
  logic [TOTAL_W-1:0] shift_amt;
  logic [WIN_W-1:0]   win_new;
  logic [TOTAL_W-1:0] total_new;
  logic [TOTAL_W-1:0] total_rem;

  // Merge the next code below the pending bits
  always_comb begin
    shift_amt = TOTAL_W'(WIN_W) - TOTAL_W'(total_q[2:0]) - TOTAL_W'(head_i.len);
    win_new   = {window_q[WIN_W-1 -: BYTE_W], {(WIN_W - BYTE_W){1'b0}}} |
                (WIN_W'(head_i.code) << shift_amt);
    total_new = TOTAL_W'(total_q[2:0]) + TOTAL_W'(head_i.len);
    total_rem = total_q - TOTAL_W'(BYTE_W);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;

  // State, window and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= '0;
      total_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (!qstat_i.empty) begin
            window_q <= win_new;
            total_q  <= total_new;
            last_q   <= head_i.last;
            if ((total_new >= TOTAL_W'(BYTE_W)) || head_i.last) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_byte_q  <= window_q[WIN_W-1 -: BYTE_W];
            if (total_q >= TOTAL_W'(BYTE_W)) begin
              // full byte
              out_last_q <= 1'b0;
              window_q   <= window_q << BYTE_W;
              total_q    <= total_rem;
              if ((total_rem < TOTAL_W'(BYTE_W)) && !last_q) begin
                state_q <= ST_IDLE;
              end
            end else begin
              // flush of the zero-padded partial byte
              out_last_q <= 1'b1;
              window_q   <= '0;
              total_q    <= '0;
              state_q    <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/huffman_code_bit_packer_unit.sv
// Huffman code bit packer top level: code table lookup, queue and byte packer.
// An accepted encode word passes the table read register, the code queue and the
// packer window before its bytes reach the output register. Loads only write the
// code table. Each output byte, full or flushed, leaves through the single output byte port.
// Reset (async, active low) clears the queue and packer state; code table
// entries are undefined until loaded.
module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [SYM_W-1:0]        symbol_i,
  input  logic [CODE_FIELD_W-1:0] code_value_i,
  input  logic [LEN_FIELD_W-1:0]  code_length_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BYTE_W-1:0]       out_byte_o,
  output logic                    out_last_o
);

  logic        push;
  logic        pop;
  hcbp_entry_t entry;
  hcbp_entry_t head;
  hcbp_qstat_t qstat;

  hcbp_front #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .symbol_i      (symbol_i),
    .code_value_i  (code_value_i),
    .code_length_i (code_length_i),
    .last_i        (last_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .entry_o       (entry)
  );

  hcbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  hcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // Queue never overflows: a lookup result always finds room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (qstat.free != '0))
    else $error("code queue overflow");

  // Every accepted encode word reaches the queue in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == KIND_ENCODE)) |=> push)
    else $error("encode word lost before queue");

  // Table loads never produce queue entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == KIND_LOAD)) |=> !push)
    else $error("table load pushed into code queue");

endmodule
